[design/aic_pkg.sv]
// Shared types and constants for the analog input conditioner.
// No dependencies; every other design file imports this package.
package aic_pkg;

    // Field widths fixed by the block's ports
    localparam int SAMPLE_W   = 12;
    localparam int SCALE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Exponential accumulator, Q12.16
    localparam int ACC_W = 28;

    // Segment arithmetic: |delta in| * |delta scale| and |segment width|
    localparam int MAG_A_W = 12;
    localparam int NUM_W   = MAG_A_W + SCALE_W;
    localparam int DEN_W   = 12;

    // Serial divider retires two quotient bits per cycle
    localparam int DIV_CYCLES = NUM_W / 2;
    localparam int CNT_W      = $clog2(DIV_CYCLES);

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IN_MIN       = 3'd0,
        CFG_IN_CENTER    = 3'd1,
        CFG_IN_MAX       = 3'd2,
        CFG_SCALE_MIN    = 3'd3,
        CFG_SCALE_CENTER = 3'd4,
        CFG_SCALE_MAX    = 3'd5,
        CFG_INVERT       = 3'd6,
        CFG_LIMIT_BOUNDS = 3'd7
    } t_cfg_idx;

    // Live calibration and limit settings
    typedef struct packed {
        logic [SAMPLE_W-1:0] in_min;
        logic [SAMPLE_W-1:0] in_center;
        logic [SAMPLE_W-1:0] in_max;
        logic [SCALE_W-1:0]  scale_min;
        logic [SCALE_W-1:0]  scale_center;
        logic [SCALE_W-1:0]  scale_max;
        logic                invert;
        logic [SCALE_W-1:0]  warn_lo;
        logic [SCALE_W-1:0]  warn_hi;
        logic [SCALE_W-1:0]  alarm_lo;
        logic [SCALE_W-1:0]  alarm_hi;
    } t_cfg;

    // One classified item handed from front end to back end
    typedef struct packed {
        logic [NUM_W-1:0]    num_mag;
        logic [DEN_W-1:0]    den_mag;
        logic                q_neg;
        logic                den_zero;
        logic [SCALE_W-1:0]  base;
        logic [SAMPLE_W-1:0] avg;
    } t_job;

    typedef enum logic [2:0] {
        F_IDLE,
        F_AVG,
        F_MUL,
        F_CORR,
        F_SCALE
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_DONE,
        B_HOLD
    } t_back_state;

endpackage

[design/aic_if.sv]
// Valid/ready channel interfaces: sample input, result output, config writes.
// Depends on aic_pkg for field widths.
interface aic_in_if;
    import aic_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface aic_out_if;
    import aic_pkg::*;
    logic                valid;
    logic                ready;
    logic [SCALE_W-1:0]  scaled_value;
    logic [SAMPLE_W-1:0] averaged_sample;
    logic                warning;
    logic                alarm;
    modport source (output valid, output scaled_value, output averaged_sample,
                    output warning, output alarm, input ready);
    modport sink   (input valid, input scaled_value, input averaged_sample,
                    input warning, input alarm, output ready);
endinterface

interface aic_cfg_if;
    import aic_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[design/analog_input_condition_scale_alarm_core.sv]
// Analog input conditioner top level: averaging, three-point scaling, window alarms.
// Depends on aic_pkg, aic_if, aic_front, aic_queue and aic_back.
//
// Each accepted sample yields exactly one result beat. The front end takes a
// sample, then works through average update, reciprocal multiply or EMA
// product, correction and segment setup before it can accept the next one;
// it parks the classified item in a two-entry queue. The back end loads an
// item, runs the segment division as a 2-bit-per-cycle serial divider,
// finishes, then holds the result beat until it is taken, and only then
// takes the next item. A zero-width segment skips the divider. The averaging
// ring uses per-entry valid bits, so no clearing pass runs after reset.
// Configuration writes are always accepted and must only be issued while no
// result is outstanding.
module analog_input_condition_scale_alarm_core #(
    parameter int AVG_DEPTH     = 8,
    parameter int AVG_MODE      = 1,
    parameter int EMA_ALPHA_Q16 = 6554,
    parameter int SAMPLE_BITS   = 12
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aic_in_if.sink    i_in,
    aic_cfg_if.sink   i_cfg,
    aic_out_if.source o_out
);
    import aic_pkg::*;

    t_cfg r_cfg;
    t_job front_job;
    logic front_valid;
    logic front_ready;
    t_job back_job;
    logic back_valid;
    logic back_ready;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.in_min       <= 12'd0;
            r_cfg.in_center    <= 12'd2048;
            r_cfg.in_max       <= 12'd4095;
            r_cfg.scale_min    <= 16'd0;
            r_cfg.scale_center <= 16'd2048;
            r_cfg.scale_max    <= 16'd4095;
            r_cfg.invert       <= 1'b0;
            r_cfg.warn_lo      <= 16'd0;
            r_cfg.warn_hi      <= 16'd0;
            r_cfg.alarm_lo     <= 16'd0;
            r_cfg.alarm_hi     <= 16'd0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_IN_MIN:       r_cfg.in_min       <= i_cfg.data[SAMPLE_W-1:0];
                CFG_IN_CENTER:    r_cfg.in_center    <= i_cfg.data[SAMPLE_W-1:0];
                CFG_IN_MAX:       r_cfg.in_max       <= i_cfg.data[SAMPLE_W-1:0];
                CFG_SCALE_MIN:    r_cfg.scale_min    <= i_cfg.data[SCALE_W-1:0];
                CFG_SCALE_CENTER: r_cfg.scale_center <= i_cfg.data[SCALE_W-1:0];
                CFG_SCALE_MAX:    r_cfg.scale_max    <= i_cfg.data[SCALE_W-1:0];
                CFG_INVERT:       r_cfg.invert       <= i_cfg.data[0];
                CFG_LIMIT_BOUNDS: begin
                    r_cfg.warn_lo  <= i_cfg.data[15:0];
                    r_cfg.warn_hi  <= i_cfg.data[31:16];
                    r_cfg.alarm_lo <= i_cfg.data[47:32];
                    r_cfg.alarm_hi <= i_cfg.data[63:48];
                end
                default: begin
                end
            endcase
        end
    end

    // Front end: averaging and segment classification
    aic_front #(
        .AVG_DEPTH     (AVG_DEPTH),
        .AVG_MODE      (AVG_MODE),
        .EMA_ALPHA_Q16 (EMA_ALPHA_Q16),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in        (i_in),
        .o_job       (front_job),
        .o_job_valid (front_valid),
        .i_job_ready (front_ready)
    );

    // Decoupling queue
    aic_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_data  (front_job),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .o_rd_data  (back_job),
        .o_rd_valid (back_valid),
        .i_rd_ready (back_ready)
    );

    // Back end: divide, scale, flag, deliver
    aic_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job       (back_job),
        .i_job_valid (back_valid),
        .o_job_ready (back_ready),
        .o_out       (o_out)
    );

    // Front end works on one sample at a time
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("front end accepted a sample while busy");

    // Back end takes a new item only with its output register empty
    a_pop_empty_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (back_valid && back_ready) |-> !o_out.valid)
        else $error("queue popped while a result beat is pending");

    // Front end never accepts while it still offers a finished item
    a_offer_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_valid |-> !i_in.ready)
        else $error("front end ready while handing off an item");

endmodule

[design/aic_front.sv]
// Front end: accepts samples, averages, clamps and picks the scaling segment.
// Depends on aic_pkg and aic_in_if; feeds t_job beats to aic_queue.
module aic_front #(
    parameter int AVG_DEPTH     = 8,
    parameter int AVG_MODE      = 1,
    parameter int EMA_ALPHA_Q16 = 6554,
    parameter int SAMPLE_BITS   = 12
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  aic_pkg::t_cfg i_cfg,
    aic_in_if.sink        i_in,
    output aic_pkg::t_job o_job,
    output logic          o_job_valid,
    input  logic          i_job_ready
);
    import aic_pkg::*;

    localparam int IDX_W  = $clog2(AVG_DEPTH);
    localparam int SUM_W  = SAMPLE_W + IDX_W;
    localparam int PROD_W = 2 * SUM_W;
    localparam int EP_W   = 17 + ACC_W;
    localparam logic [SUM_W-1:0]    DEPTH_C = SUM_W'(AVG_DEPTH);
    localparam logic [SUM_W-1:0]    RECIP   = SUM_W'((1 << SUM_W) / AVG_DEPTH);
    localparam logic [15:0]         ALPHA   = 16'(EMA_ALPHA_Q16);
    localparam logic [16:0]         ALPHA_C = 17'(65536 - EMA_ALPHA_Q16);
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((32'd1 << SAMPLE_BITS) - 1);

    t_front_state r_state, n_state;
    logic [IDX_W-1:0]    r_widx, n_widx;
    logic [SUM_W-1:0]    r_sum, n_sum;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [SAMPLE_W-1:0] r_x, n_x;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [EP_W-1:0]     r_ema_prod, n_ema_prod;
    logic [SAMPLE_W-1:0] r_avg, n_avg;

    // Sample ring with per-entry valid bits (unwritten entries read as zero)
    logic [SAMPLE_W-1:0]  r_ring [AVG_DEPTH];
    logic [AVG_DEPTH-1:0] r_ring_vld;
    logic [SAMPLE_W-1:0]  r_old;
    logic                 r_old_vld;

    logic accept;
    logic ring_we;

    assign i_in.ready = (r_state == F_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign ring_we    = (r_state == F_AVG) && (AVG_MODE == 1);

    // Ring memory: registered read of the slot about to be overwritten
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_old     <= r_ring[r_widx];
            r_old_vld <= r_ring_vld[r_widx];
        end
        if (ring_we) begin
            r_ring[r_widx] <= r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld <= '0;
        end else if (ring_we) begin
            r_ring_vld[r_widx] <= 1'b1;
        end
    end

    // Control state and running averages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_widx  <= '0;
            r_sum   <= '0;
            r_acc   <= '0;
        end else begin
            r_state <= n_state;
            r_widx  <= n_widx;
            r_sum   <= n_sum;
            r_acc   <= n_acc;
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_prod     <= n_prod;
        r_ema_prod <= n_ema_prod;
        r_avg      <= n_avg;
    end

    // Sequencer: average (running sum or EMA), reciprocal multiply or EMA update, correction, then hand off
    always_comb begin
        logic [SAMPLE_W-1:0] old_val;
        logic [SUM_W-1:0]    q0;
        logic [SUM_W-1:0]    qd;
        logic [SUM_W-1:0]    rem;
        logic [SUM_W-1:0]    qf;
        logic [ACC_W-1:0]    ax;

        n_state    = r_state;
        n_widx     = r_widx;
        n_sum      = r_sum;
        n_acc      = r_acc;
        n_x        = r_x;
        n_prod     = r_prod;
        n_ema_prod = r_ema_prod;
        n_avg      = r_avg;
        old_val    = r_old_vld ? r_old : '0;
        q0         = r_prod[PROD_W-1:SUM_W];
        qd         = q0 * DEPTH_C;
        rem        = r_sum - qd;
        qf         = q0 + SUM_W'(rem >= DEPTH_C);
        ax         = ACC_W'(ALPHA) * ACC_W'(r_x);

        case (r_state)
            F_IDLE: begin
                if (accept) begin
                    n_x     = i_in.sample & SAMPLE_MASK;
                    n_state = F_AVG;
                end
            end
            F_AVG: begin
                if (AVG_MODE == 1) begin
                    n_sum  = r_sum - SUM_W'(old_val) + SUM_W'(r_x);
                    n_widx = (r_widx == IDX_W'(AVG_DEPTH - 1)) ? '0 : r_widx + 1'b1;
                end else if (AVG_MODE == 2) begin
                    n_ema_prod = EP_W'(ALPHA_C) * EP_W'(r_acc);
                end
                n_state = F_MUL;
            end
            F_MUL: begin
                if (AVG_MODE == 1) begin
                    n_prod = PROD_W'(r_sum) * PROD_W'(RECIP);
                end else if (AVG_MODE == 2) begin
                    n_acc = ax + ACC_W'(r_ema_prod[EP_W-1:16]);
                end
                n_state = F_CORR;
            end
            F_CORR: begin
                // Reciprocal estimate is low by at most one
                if (AVG_MODE == 1) begin
                    n_avg = qf[SAMPLE_W-1:0];
                end else if (AVG_MODE == 2) begin
                    n_avg = r_acc[ACC_W-1:16];
                end else begin
                    n_avg = r_x;
                end
                n_state = F_SCALE;
            end
            F_SCALE: begin
                if (i_job_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    // Clamp and segment selection; magnitudes and signs for the divider
    always_comb begin
        logic [SAMPLE_W-1:0]      d;
        logic signed [SAMPLE_W:0] diff_a;
        logic signed [SCALE_W:0]  diff_b;
        logic signed [SAMPLE_W:0] diff_d;
        logic [MAG_A_W-1:0]       a_mag;
        logic [SCALE_W-1:0]       b_mag;

        if (r_avg < i_cfg.in_min) begin
            d = i_cfg.in_min;
        end else if (r_avg > i_cfg.in_max) begin
            d = i_cfg.in_max;
        end else begin
            d = r_avg;
        end

        if (d < i_cfg.in_center) begin
            o_job.base = i_cfg.scale_min;
            diff_a = $signed({1'b0, d} - {1'b0, i_cfg.in_min});
            diff_b = $signed({1'b0, i_cfg.scale_center} - {1'b0, i_cfg.scale_min});
            diff_d = $signed({1'b0, i_cfg.in_center} - {1'b0, i_cfg.in_min});
        end else begin
            o_job.base = i_cfg.scale_center;
            diff_a = $signed({1'b0, d} - {1'b0, i_cfg.in_center});
            diff_b = $signed({1'b0, i_cfg.scale_max} - {1'b0, i_cfg.scale_center});
            diff_d = $signed({1'b0, i_cfg.in_max} - {1'b0, i_cfg.in_center});
        end

        a_mag = diff_a[SAMPLE_W] ? MAG_A_W'(-diff_a) : diff_a[MAG_A_W-1:0];
        b_mag = diff_b[SCALE_W]  ? SCALE_W'(-diff_b) : diff_b[SCALE_W-1:0];

        o_job.num_mag  = NUM_W'(a_mag) * NUM_W'(b_mag);
        o_job.den_mag  = diff_d[SAMPLE_W] ? DEN_W'(-diff_d) : diff_d[DEN_W-1:0];
        o_job.q_neg    = diff_a[SAMPLE_W] ^ diff_b[SCALE_W] ^ diff_d[SAMPLE_W];
        o_job.den_zero = (diff_d == '0);
        o_job.avg      = r_avg;
    end

    assign o_job_valid = (r_state == F_SCALE);

endmodule

[design/aic_queue.sv]
// Two-entry queue of t_job beats between front end and back end.
// Depends on aic_pkg.
module aic_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  aic_pkg::t_job i_wr_data,
    input  logic          i_wr_valid,
    output logic          o_wr_ready,
    output aic_pkg::t_job o_rd_data,
    output logic          o_rd_valid,
    input  logic          i_rd_ready
);
    import aic_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_wr_ready = (r_cnt != 2'd2);
    assign o_rd_valid = (r_cnt != 2'd0);
    assign o_rd_data  = r_mem[r_rp];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_wr_data;
        end
    end

endmodule

[design/aic_back.sv]
// Back end: serial signed divide, offset, invert, window flags, output register.
// Depends on aic_pkg and aic_out_if; takes t_job beats from aic_queue.
module aic_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  aic_pkg::t_cfg i_cfg,
    input  aic_pkg::t_job i_job,
    input  logic          i_job_valid,
    output logic          o_job_ready,
    aic_out_if.source     o_out
);
    import aic_pkg::*;

    t_back_state r_state, n_state;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [NUM_W-1:0]    r_num, n_num;
    logic [DEN_W-1:0]    r_den, n_den;
    logic [DEN_W-1:0]    r_rem, n_rem;
    logic [SCALE_W-1:0]  r_quo, n_quo;
    logic                r_qneg, n_qneg;
    logic [SCALE_W-1:0]  r_base, n_base;
    logic [SAMPLE_W-1:0] r_avg, n_avg;
    logic [SCALE_W-1:0]  r_out_val, n_out_val;
    logic                r_out_warn, n_out_warn;
    logic                r_out_alarm, n_out_alarm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_num       <= n_num;
        r_den       <= n_den;
        r_rem       <= n_rem;
        r_quo       <= n_quo;
        r_qneg      <= n_qneg;
        r_base      <= n_base;
        r_avg       <= n_avg;
        r_out_val   <= n_out_val;
        r_out_warn  <= n_out_warn;
        r_out_alarm <= n_out_alarm;
    end

    // Load, divide two bits per cycle, finish, hold the result beat
    always_comb begin
        logic [DEN_W:0]     rem_w;
        logic [NUM_W-1:0]   num_w;
        logic [SCALE_W-1:0] quo_w;
        logic [SCALE_W-1:0] sq;
        logic [SCALE_W-1:0] v;

        n_state     = r_state;
        n_cnt       = r_cnt;
        n_num       = r_num;
        n_den       = r_den;
        n_rem       = r_rem;
        n_quo       = r_quo;
        n_qneg      = r_qneg;
        n_base      = r_base;
        n_avg       = r_avg;
        n_out_val   = r_out_val;
        n_out_warn  = r_out_warn;
        n_out_alarm = r_out_alarm;
        o_job_ready = 1'b0;

        // Two restoring-division steps; only the low quotient bits are kept
        rem_w = {1'b0, r_rem};
        num_w = r_num;
        quo_w = r_quo;
        for (int k = 0; k < 2; k++) begin
            rem_w = {rem_w[DEN_W-1:0], num_w[NUM_W-1]};
            num_w = {num_w[NUM_W-2:0], 1'b0};
            if (rem_w >= {1'b0, r_den}) begin
                rem_w = rem_w - {1'b0, r_den};
                quo_w = {quo_w[SCALE_W-2:0], 1'b1};
            end else begin
                quo_w = {quo_w[SCALE_W-2:0], 1'b0};
            end
        end

        // Signed quotient added to the segment base, wrapped to 16 bits, then inverted against scale_max when set
        sq = r_qneg ? (~r_quo + 1'b1) : r_quo;
        v  = r_base + sq;
        if (i_cfg.invert) begin
            v = i_cfg.scale_max - v;
        end

        case (r_state)
            B_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_num   = i_job.num_mag;
                    n_den   = i_job.den_mag;
                    n_qneg  = i_job.q_neg;
                    n_base  = i_job.base;
                    n_avg   = i_job.avg;
                    n_rem   = '0;
                    n_quo   = '0;
                    n_cnt   = '0;
                    n_state = i_job.den_zero ? B_DONE : B_DIV;
                end
            end
            B_DIV: begin
                n_rem = rem_w[DEN_W-1:0];
                n_num = num_w;
                n_quo = quo_w;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_CYCLES - 1)) begin
                    n_state = B_DONE;
                end
            end
            B_DONE: begin
                n_out_val   = v;
                n_out_warn  = (v >= i_cfg.warn_lo) && (v <= i_cfg.warn_hi);
                n_out_alarm = (v >= i_cfg.alarm_lo) && (v <= i_cfg.alarm_hi);
                n_state     = B_HOLD;
            end
            B_HOLD: begin
                if (o_out.ready) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    assign o_out.valid           = (r_state == B_HOLD);
    assign o_out.scaled_value    = r_out_val;
    assign o_out.averaged_sample = r_avg;
    assign o_out.warning         = r_out_warn;
    assign o_out.alarm           = r_out_alarm;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the analog input conditioner core.
// Uses aic_pkg and the aic_in_if / aic_cfg_if / aic_out_if channel interfaces.
// It runs a directed script first, then random calibration phases checked by a predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import aic_pkg::*;

    // Build configuration of the core under test
    localparam int AVG_DEPTH     = 8;
    localparam int AVG_MODE      = 1;
    localparam int EMA_ALPHA_Q16 = 6554;
    localparam int SAMPLE_BITS   = 12;
    localparam int RAND_PHASES   = 10;
    localparam int PHASE_ITEMS   = 108;
    localparam int TAIL_CYCLES   = 40;

    // One result beat as the output channel carries it
    typedef struct packed {
        logic [SCALE_W-1:0]  scaled_value;
        logic [SAMPLE_W-1:0] averaged_sample;
        logic                warning;
        logic                alarm;
    } t_reading;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    // Directed script row: a sample beat or a register write
    typedef struct packed {
        t_row_kind kind;
        t_cfg_idx  idx;
        logic [63:0] value;
        logic        typed;
        t_reading    want;
    } t_step;

    logic i_clk = 1'b0;
    logic i_rst_n;

    aic_in_if  in_if ();
    aic_cfg_if cfg_if ();
    aic_out_if out_if ();

    analog_input_condition_scale_alarm_core #(
        .AVG_DEPTH    (AVG_DEPTH),
        .AVG_MODE     (AVG_MODE),
        .EMA_ALPHA_Q16(EMA_ALPHA_Q16),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .i_cfg  (cfg_if),
        .o_out  (out_if)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state: live settings plus the averaging history
    t_cfg        setup;
    int unsigned avg_ring [AVG_DEPTH];
    int unsigned ring_pos;
    int unsigned ring_total;
    logic [63:0] ema_state;

    t_reading pending_readings [$];
    t_reading oldest;
    int       errors = 0;
    bit       no_gaps = 1'b0;

    // Directed script: reset values, extremes, zero-width segments, crossed
    // ranges and windows, descending and inverted scales
    t_step script [40] = '{
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd0,    1'b1, '{16'd0,    12'd0,    1'b1, 1'b1}},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095, 1'b1, '{16'd511,  12'd511,  1'b0, 1'b0}},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095, 1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095, 1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095, 1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095, 1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095, 1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095, 1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095, 1'b1, '{16'd4095, 12'd4095, 1'b0, 1'b0}},
        // full warn window, crossed alarm window
        '{ROW_WRITE,  CFG_LIMIT_BOUNDS, 64'h0004_0005_FFFF_0000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095, 1'b1, '{16'd4095, 12'd4095, 1'b1, 1'b0}},
        // upper segment of zero width
        '{ROW_WRITE,  CFG_IN_MAX, 64'd2048, 1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095, 1'b1, '{16'd2048, 12'd4095, 1'b1, 1'b0}},
        '{ROW_WRITE,  CFG_INVERT, 64'd1,    1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095, 1'b1, '{16'd2047, 12'd4095, 1'b1, 1'b0}},
        // lower segment of zero width under a crossed input range
        '{ROW_WRITE,  CFG_INVERT,    64'd0,    1'b0, '0},
        '{ROW_WRITE,  CFG_IN_MIN,    64'd3000, 1'b0, '0},
        '{ROW_WRITE,  CFG_IN_CENTER, 64'd3000, 1'b0, '0},
        '{ROW_WRITE,  CFG_IN_MAX,    64'd1000, 1'b0, '0},
        '{ROW_WRITE,  CFG_SCALE_MIN, 64'd1234, 1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095, 1'b1, '{16'd1234, 12'd4095, 1'b1, 1'b0}},
        // crossed range with negative differences
        '{ROW_WRITE,  CFG_IN_CENTER, 64'd2048, 1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd0,    1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095, 1'b0, '0},
        // descending scale points
        '{ROW_WRITE,  CFG_IN_MIN,       64'd0,     1'b0, '0},
        '{ROW_WRITE,  CFG_IN_MAX,       64'd4095,  1'b0, '0},
        '{ROW_WRITE,  CFG_SCALE_MIN,    64'd65535, 1'b0, '0},
        '{ROW_WRITE,  CFG_SCALE_CENTER, 64'd100,   1'b0, '0},
        '{ROW_WRITE,  CFG_SCALE_MAX,    64'd0,     1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095, 1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd0,    1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd2000, 1'b0, '0},
        // top of the scale, inverted
        '{ROW_WRITE,  CFG_SCALE_MIN,    64'd0,     1'b0, '0},
        '{ROW_WRITE,  CFG_SCALE_CENTER, 64'd65535, 1'b0, '0},
        '{ROW_WRITE,  CFG_SCALE_MAX,    64'd65535, 1'b0, '0},
        '{ROW_WRITE,  CFG_INVERT,       64'd1,     1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd4095,  1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'd0,     1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'h555,   1'b0, '0},
        '{ROW_SAMPLE, CFG_IN_MIN, 64'hAAA,   1'b0, '0}
    };

    // Settings and averaging history as they stand after reset
    function automatic void clear_predictor();
        setup              = '0;
        setup.in_center    = 12'd2048;
        setup.in_max       = 12'd4095;
        setup.scale_center = 16'd2048;
        setup.scale_max    = 16'd4095;
        foreach (avg_ring[i]) avg_ring[i] = 0;
        ring_pos   = 0;
        ring_total = 0;
        ema_state  = '0;
    endfunction

    function automatic void apply_setting(input t_cfg_idx idx, input logic [63:0] value);
        case (idx)
            CFG_IN_MIN:       setup.in_min       = value[SAMPLE_W-1:0];
            CFG_IN_CENTER:    setup.in_center    = value[SAMPLE_W-1:0];
            CFG_IN_MAX:       setup.in_max       = value[SAMPLE_W-1:0];
            CFG_SCALE_MIN:    setup.scale_min    = value[SCALE_W-1:0];
            CFG_SCALE_CENTER: setup.scale_center = value[SCALE_W-1:0];
            CFG_SCALE_MAX:    setup.scale_max    = value[SCALE_W-1:0];
            CFG_INVERT:       setup.invert       = value[0];
            CFG_LIMIT_BOUNDS: begin
                setup.warn_lo  = value[15:0];
                setup.warn_hi  = value[31:16];
                setup.alarm_lo = value[47:32];
                setup.alarm_hi = value[63:48];
            end
            default: ;
        endcase
    endfunction

    // Average, clamp, three-point scale, invert and window-test one sample
    function automatic t_reading condition_sample(input logic [SAMPLE_W-1:0] raw);
        logic [63:0]  x;
        logic [63:0]  prod;
        int unsigned  mean;
        longint       d, base, num_a, num_b, den, s;
        logic [15:0]  v;
        t_reading     r;
        x = 64'(raw) & ((64'd1 << SAMPLE_BITS) - 64'd1);
        if (AVG_MODE == 1) begin
            ring_total         = ring_total - avg_ring[ring_pos] + int'(x);
            avg_ring[ring_pos] = int'(x);
            ring_pos           = (ring_pos + 1) % AVG_DEPTH;
            mean               = ring_total / AVG_DEPTH;
        end else if (AVG_MODE == 2) begin
            prod = 64'(EMA_ALPHA_Q16) * (x << 16)
                 + (64'd65536 - 64'(EMA_ALPHA_Q16)) * ema_state;
            ema_state = (prod >> 16) & ((64'd1 << (SAMPLE_BITS + 16)) - 64'd1);
            mean      = int'(ema_state >> 16);
        end else begin
            mean = int'(x);
        end

        // below-minimum test wins when the range is crossed
        if (mean < setup.in_min)      d = setup.in_min;
        else if (mean > setup.in_max) d = setup.in_max;
        else                          d = mean;

        if (d < longint'(setup.in_center)) begin
            base  = setup.scale_min;
            num_a = d - longint'(setup.in_min);
            num_b = longint'(setup.scale_center) - longint'(setup.scale_min);
            den   = longint'(setup.in_center) - longint'(setup.in_min);
        end else begin
            base  = setup.scale_center;
            num_a = d - longint'(setup.in_center);
            num_b = longint'(setup.scale_max) - longint'(setup.scale_center);
            den   = longint'(setup.in_max) - longint'(setup.in_center);
        end
        s = (den == 0) ? base : base + (num_a * num_b) / den;
        v = s[15:0];
        if (setup.invert) v = setup.scale_max - v;

        r.scaled_value    = v;
        r.averaged_sample = mean[SAMPLE_W-1:0];
        r.warning         = (v >= setup.warn_lo) && (v <= setup.warn_hi);
        r.alarm           = (v >= setup.alarm_lo) && (v <= setup.alarm_hi);
        return r;
    endfunction

    // Register write: only once every outstanding result has come back
    task automatic write_register(input t_cfg_idx idx, input logic [63:0] value);
        in_if.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        apply_setting(idx, value);
    endtask

    // One sample beat with random idle cycles ahead of it, unless no_gaps is set
    task automatic send_sample(input logic [SAMPLE_W-1:0] raw, input logic typed,
                               input t_reading want);
        t_reading got;
        cfg_if.valid <= 1'b0;
        while (!no_gaps && $urandom_range(99) < 33) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid  <= 1'b1;
        in_if.sample <= raw;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        got = condition_sample(raw);
        pending_readings.push_back(typed ? want : got);
    endtask

    function automatic logic [31:0] random_window();
        logic [15:0] lo, hi, tmp;
        lo = 16'($urandom_range(0, 65535));
        hi = 16'($urandom_range(0, 65535));
        // mostly ordered windows; the rest stay as drawn, often crossed
        if ($urandom_range(3) != 0 && lo > hi) begin
            tmp = lo;
            lo  = hi;
            hi  = tmp;
        end
        return {hi, lo};
    endfunction

    // New calibration: 0 ordered, 1 crossed, 2 extremes, 3 zero-width segment
    task automatic program_random_setup(input int kind);
        logic [11:0] p0, p1, p2, tmp;
        logic [15:0] s0, s1, s2;
        p0 = 12'($urandom_range(0, 4095));
        p1 = 12'($urandom_range(0, 4095));
        p2 = 12'($urandom_range(0, 4095));
        if (p0 > p1) begin tmp = p0; p0 = p1; p1 = tmp; end
        if (p1 > p2) begin tmp = p1; p1 = p2; p2 = tmp; end
        if (p0 > p1) begin tmp = p0; p0 = p1; p1 = tmp; end
        s0 = 16'($urandom_range(0, 65535));
        s1 = 16'($urandom_range(0, 65535));
        s2 = 16'($urandom_range(0, 65535));
        case (kind)
            1: begin
                tmp = p0;
                p0  = p2;
                p2  = tmp;
            end
            2: begin
                p0 = $urandom_range(1) ? 12'hFFF : 12'h000;
                p1 = $urandom_range(1) ? 12'hFFF : 12'h000;
                p2 = $urandom_range(1) ? 12'hFFF : 12'h000;
                s0 = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                s1 = $urandom_range(1) ? 16'hFFFF : 16'h0000;
                s2 = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            end
            3: begin
                if ($urandom_range(1)) p1 = p2;
                else begin
                    p1  = p0;
                    tmp = p0;
                    p0  = p2;
                    p2  = tmp;
                end
            end
            default: ;
        endcase
        write_register(CFG_IN_MIN, 64'(p0));
        write_register(CFG_IN_CENTER, 64'(p1));
        write_register(CFG_IN_MAX, 64'(p2));
        write_register(CFG_SCALE_MIN, 64'(s0));
        write_register(CFG_SCALE_CENTER, 64'(s1));
        write_register(CFG_SCALE_MAX, 64'(s2));
        write_register(CFG_INVERT, 64'($urandom_range(1)));
        write_register(CFG_LIMIT_BOUNDS, {random_window(), random_window()});
    endtask

    // Result side backpressure
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_if.ready <= no_gaps || ($urandom_range(99) >= 33);
        end
    end

    // Result checker: every beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_readings.size() == 0) begin
                $error("result beat with no sample outstanding");
                errors++;
            end else begin
                oldest = pending_readings.pop_front();
                if (out_if.scaled_value !== oldest.scaled_value) begin
                    $error("scaled_value: expected %0d, got %0d",
                           oldest.scaled_value, out_if.scaled_value);
                    errors++;
                end
                if (out_if.averaged_sample !== oldest.averaged_sample) begin
                    $error("averaged_sample: expected %0d, got %0d",
                           oldest.averaged_sample, out_if.averaged_sample);
                    errors++;
                end
                if (out_if.warning !== oldest.warning) begin
                    $error("warning: expected %0b, got %0b", oldest.warning, out_if.warning);
                    errors++;
                end
                if (out_if.alarm !== oldest.alarm) begin
                    $error("alarm: expected %0b, got %0b", oldest.alarm, out_if.alarm);
                    errors++;
                end
            end
        end
    end

    // Stimulus
    initial begin
        logic [11:0] level;
        int          pick;
        in_if.valid   <= 1'b0;
        in_if.sample  <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= CFG_IN_MIN;
        cfg_if.data   <= '0;
        i_rst_n       <= 1'b0;
        clear_predictor();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) write_register(script[i].idx, script[i].value);
            else send_sample(script[i].value[11:0], script[i].typed, script[i].want);
        end

        // random phases: mostly held levels so the average settles on them
        for (int phase = 0; phase < RAND_PHASES; phase++) begin
            no_gaps = (phase == RAND_PHASES / 2);
            program_random_setup(phase % 4);
            level = 12'($urandom_range(0, 4095));
            repeat (PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 15)      level = 12'($urandom_range(0, 4095));
                else if (pick < 25) level = $urandom_range(1) ? 12'hFFF : 12'h000;
                else if (pick < 32) level = setup.in_center + 12'($urandom_range(0, 6)) - 12'd3;
                else if (pick < 36) level = setup.in_min + 12'($urandom_range(0, 6)) - 12'd3;
                else if (pick < 40) level = setup.in_max + 12'($urandom_range(0, 6)) - 12'd3;
                if ($urandom_range(99) < 20)
                    send_sample(12'($urandom_range(0, 4095)), 1'b0, '0);
                else
                    send_sample(level, 1'b0, '0);
            end
        end
        no_gaps = 1'b0;

        // drain, then let the pipeline go quiet
        in_if.valid  <= 1'b0;
        cfg_if.valid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
